// ===== src/apt_pkg.sv =====
// shared types and constants for the alternating pressure target block
package apt_pkg;

  localparam int unsigned PRESSURE_W  = 12;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned WEIGHT_W    = 8;
  localparam int unsigned QUARTERS_W  = 8;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned REG_IDX_W   = 3;

  // auto phase length is quarters * 250000, at most 26 bits
  localparam int unsigned AUTO_LEN_W  = 26;
  localparam logic [AUTO_LEN_W-1:0] US_PER_QUARTER = AUTO_LEN_W'(250000);

  localparam logic [PRESSURE_W-1:0] LOW_DEFAULT_PRESSURE = PRESSURE_W'(400);
  localparam logic [PRESSURE_W-1:0] PRESSURE_MAX         = PRESSURE_W'(4095);

  // divider: w*smoothed + p fits 20 bits, carried in an even count of 22 bits for radix-4
  localparam int unsigned NUM_W       = 22;
  localparam int unsigned DEN_W       = WEIGHT_W + 1;
  localparam int unsigned DIV_BITS    = 2;
  localparam int unsigned DIV_STEPS   = NUM_W / DIV_BITS;
  localparam int unsigned DIV_CNT_W   = 4;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_AUTO_HIGH_PRESSURE  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_AUTO_PERIOD_QUARTERS = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_HIGH_PRESSURE_OVR   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LOW_PRESSURE_OVR    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_HIGH_LENGTH_OVR     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LOW_LENGTH_OVR      = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SMOOTHING_WEIGHT    = 3'd6;

  typedef struct packed {
    logic [PRESSURE_W-1:0] auto_high_pressure;
    logic [QUARTERS_W-1:0] auto_period_quarters;
    logic [PRESSURE_W-1:0] high_pressure_override;
    logic [PRESSURE_W-1:0] low_pressure_override;
    logic [TIME_W-1:0]     high_length_override_us;
    logic [TIME_W-1:0]     low_length_override_us;
    logic [WEIGHT_W-1:0]   smoothing_weight;
  } apt_cfg_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [PRESSURE_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== src/apt_if.sv =====
// tick and result channel interfaces
interface apt_tick_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_us;
  logic        therapy_active;

  modport source(output valid, output now_us, output therapy_active, input ready);
  modport sink(input valid, input now_us, input therapy_active, output ready);
endinterface

interface apt_result_if;
  logic        valid;
  logic        ready;
  logic [11:0] target_pressure;
  logic        phase_high;
  logic        applied;

  modport source(output valid, output target_pressure, output phase_high,
                 output applied, input ready);
  modport sink(input valid, input target_pressure, input phase_high,
               input applied, output ready);
endinterface

// ===== src/alternating_pressure_target_top.sv =====
// top level of the alternating pressure target generator
// an active tick passes through the length, compare and numerator states, the
// iterative divider (two quotient bits per step), writeback and the output
// register; an inactive tick goes straight to writeback and the output register
// throughput: one tick at a time; a new tick is taken only after writeback has passed the last result on
// reset: synchronous active-high rst restores register defaults and clears phase state
module alternating_pressure_target_top (
  input  logic                            clk,
  input  logic                            rst,
  apt_tick_if.sink                        tick,
  apt_result_if.source                    result,
  input  logic                            cfg_we,
  input  logic [apt_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [apt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import apt_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LEN  = 6'b000010,
    S_CMP  = 6'b000100,
    S_NUM  = 6'b001000,
    S_DIV  = 6'b010000,
    S_WB   = 6'b100000
  } state_t;

  state_t   state;
  apt_cfg_t cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // captured tick
  logic [TIME_W-1:0]     now;

  // phase and smoothing state
  logic                  initialized;
  logic                  phase;
  logic [TIME_W-1:0]     phase_start;
  logic [PRESSURE_W-1:0] smoothed;
  logic [PRESSURE_W-1:0] smoothed_next;

  // per-tick working registers
  logic [TIME_W-1:0]     elapsed;
  logic [TIME_W-1:0]     len;

  // finished result waiting for the output register
  logic [PRESSURE_W-1:0] pend_target;
  logic                  pend_phase;
  logic                  pend_applied;

  // output register
  logic                  out_valid;
  logic [PRESSURE_W-1:0] out_target;
  logic                  out_phase;
  logic                  out_applied;

  logic                  phase_eff;
  logic [TIME_W-1:0]     start_eff;
  logic [AUTO_LEN_W-1:0] auto_len;
  logic [TIME_W-1:0]     len_sel;
  logic [PRESSURE_W-1:0] phase_p;
  logic                  out_free;

  apt_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  apt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // first active tick starts in the low phase at the current time
  assign phase_eff = initialized ? phase : 1'b0;
  assign start_eff = initialized ? phase_start : now;

  // default phase length from quarter seconds
  assign auto_len = AUTO_LEN_W'(cfg.auto_period_quarters) * US_PER_QUARTER;

  always_comb begin
    if (phase_eff && cfg.high_length_override_us != '0) begin
      len_sel = cfg.high_length_override_us;
    end else if (!phase_eff && cfg.low_length_override_us != '0) begin
      len_sel = cfg.low_length_override_us;
    end else begin
      len_sel = TIME_W'(auto_len);
    end
  end

  // phase pressure, taken after any toggle
  always_comb begin
    if (phase) begin
      phase_p = (cfg.high_pressure_override != '0) ? cfg.high_pressure_override
                                                    : cfg.auto_high_pressure;
    end else begin
      phase_p = (cfg.low_pressure_override != '0) ? cfg.low_pressure_override
                                                   : LOW_DEFAULT_PRESSURE;
    end
  end

  // divider request: (w*smoothed + p) / (w+1)
  assign div_req.start = (state == S_NUM);
  assign div_req.num   = NUM_W'(cfg.smoothing_weight) * NUM_W'(smoothed) + NUM_W'(phase_p);
  assign div_req.den   = DEN_W'(cfg.smoothing_weight) + DEN_W'(1);

  // dither: +1 on odd timestamps saturating, -1 on even clamped at zero
  always_comb begin
    if (now[0]) begin
      smoothed_next = (div_rsp.quot == PRESSURE_MAX) ? PRESSURE_MAX
                                                     : div_rsp.quot + 1'b1;
    end else begin
      smoothed_next = (div_rsp.quot == '0) ? '0 : div_rsp.quot - 1'b1;
    end
  end

  assign out_free = !out_valid || result.ready;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      initialized <= 1'b0;
      phase       <= 1'b0;
      phase_start <= '0;
      smoothed    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (tick.valid) begin
            state <= tick.therapy_active ? S_LEN : S_WB;
          end
        end
        S_LEN: begin
          if (!initialized) begin
            initialized <= 1'b1;
            phase       <= 1'b0;
            phase_start <= now;
          end
          state <= S_CMP;
        end
        S_CMP: begin
          if (elapsed > len) begin
            phase       <= ~phase;
            phase_start <= now;
          end
          state <= S_NUM;
        end
        S_NUM: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            smoothed <= smoothed_next;
            state    <= S_WB;
          end
        end
        S_WB: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // working payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && tick.valid) begin
      now          <= tick.now_us;
      pend_target  <= '0;
      pend_phase   <= 1'b0;
      pend_applied <= 1'b0;
    end
    if (state == S_LEN) begin
      elapsed <= now - start_eff;
      len     <= len_sel;
    end
    if (state == S_DIV && div_rsp.done) begin
      pend_target  <= smoothed_next;
      pend_phase   <= phase;
      pend_applied <= 1'b1;
    end
  end

  // output register, loads only while it is empty or its result is being taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_WB && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_WB && out_free) begin
      out_target  <= pend_target;
      out_phase   <= pend_phase;
      out_applied <= pend_applied;
    end
  end

  assign tick.ready             = (state == S_IDLE);
  assign result.valid           = out_valid;
  assign result.target_pressure = out_target;
  assign result.phase_high      = out_phase;
  assign result.applied         = out_applied;

`ifndef SYNTHESIS
  // an inactive result carries zero target and low phase
  a_inactive_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.applied) |-> (result.target_pressure == '0 && !result.phase_high))
    else $error("inactive result carries nonzero payload");

  // divider finishes only while the sequencer waits on it
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV))
    else $error("divider done outside divide wait");

  // one request at a time
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (tick.valid && tick.ready) |=> !tick.ready)
    else $error("request accepted while busy");

  // smoothed target moves only when a division completes
  a_smoothed_hold: assert property (@(posedge clk) disable iff (rst)
    (!rst && state != S_DIV) |=> $stable(smoothed))
    else $error("smoothed target changed outside divide");
`endif

endmodule

// ===== src/apt_cfg_regs.sv =====
// configuration register bank with write decode
module apt_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [apt_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [apt_pkg::CFG_DATA_W-1:0]      cfg_data,
  output apt_pkg::apt_cfg_t                   cfg
);
  import apt_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.auto_high_pressure      <= PRESSURE_W'(1000);
      cfg.auto_period_quarters    <= QUARTERS_W'(16);
      cfg.high_pressure_override  <= '0;
      cfg.low_pressure_override   <= '0;
      cfg.high_length_override_us <= '0;
      cfg.low_length_override_us  <= '0;
      cfg.smoothing_weight        <= WEIGHT_W'(3);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AUTO_HIGH_PRESSURE:   cfg.auto_high_pressure      <= cfg_data[PRESSURE_W-1:0];
        REG_AUTO_PERIOD_QUARTERS: cfg.auto_period_quarters    <= cfg_data[QUARTERS_W-1:0];
        REG_HIGH_PRESSURE_OVR:    cfg.high_pressure_override  <= cfg_data[PRESSURE_W-1:0];
        REG_LOW_PRESSURE_OVR:     cfg.low_pressure_override   <= cfg_data[PRESSURE_W-1:0];
        REG_HIGH_LENGTH_OVR:      cfg.high_length_override_us <= cfg_data[TIME_W-1:0];
        REG_LOW_LENGTH_OVR:       cfg.low_length_override_us  <= cfg_data[TIME_W-1:0];
        REG_SMOOTHING_WEIGHT:     cfg.smoothing_weight        <= cfg_data[WEIGHT_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== src/apt_div.sv =====
// iterative restoring divider, two quotient bits per cycle
module apt_div (
  input  logic              clk,
  input  logic              rst,
  input  apt_pkg::div_req_t req,
  output apt_pkg::div_rsp_t rsp
);
  import apt_pkg::*;

  logic [DEN_W-1:0]     rem;
  logic [DEN_W-1:0]     rem_next;
  logic [NUM_W-1:0]     qsh;
  logic [NUM_W-1:0]     qsh_next;
  logic [DEN_W-1:0]     den;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;

  // two dependent shift-subtract steps
  always_comb begin
    logic [DEN_W:0] t;
    rem_next = rem;
    qsh_next = qsh;
    for (int i = 0; i < DIV_BITS; i++) begin
      t = {rem_next, qsh_next[NUM_W-1]};
      qsh_next = {qsh_next[NUM_W-2:0], 1'b0};
      if (t >= {1'b0, den}) begin
        t = t - {1'b0, den};
        qsh_next[0] = 1'b1;
      end
      rem_next = t[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      qsh <= req.num;
      den <= req.den;
    end else if (busy) begin
      rem <= rem_next;
      qsh <= qsh_next;
    end
  end

  // weighted average never exceeds 4095, so the low bits hold the whole quotient
  assign rsp.done = done;
  assign rsp.quot = qsh[PRESSURE_W-1:0];

endmodule

// ===== dv/apt_target_compare.sv =====
// result predictor and comparator for the alternating pressure target block
`timescale 1ns / 1ps

module apt_target_compare (
  input  logic                            clk,
  input  logic                            rst,
  apt_tick_if                             tick,
  apt_result_if                           result,
  input  logic                            cfg_we,
  input  logic [apt_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [apt_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              mismatches,
  output int                              outstanding
);
  import apt_pkg::*;

  typedef struct packed {
    logic [PRESSURE_W-1:0] target_pressure;
    logic                  phase_high;
    logic                  applied;
  } target_result_t;

  apt_cfg_t              regs;
  logic                  initialized;
  logic                  in_high_phase;
  logic [TIME_W-1:0]     phase_start;
  logic [PRESSURE_W-1:0] smoothed;

  target_result_t expected_targets[$];
  int fails = 0;
  int waiting = 0;

  assign mismatches  = fails;
  assign outstanding = waiting;

  // advances the phase and smoothing state by one tick
  function automatic target_result_t next_target(input logic [TIME_W-1:0] now,
                                                 input logic active);
    target_result_t r;
    logic [TIME_W-1:0] len;
    logic [TIME_W-1:0] elapsed;
    logic [PRESSURE_W-1:0] p;
    int unsigned w;
    int unsigned avg;
    r = '0;
    if (!active) return r;
    if (!initialized) begin
      in_high_phase = 1'b0;
      phase_start   = now;
      initialized   = 1'b1;
    end
    if (in_high_phase && regs.high_length_override_us != '0)
      len = regs.high_length_override_us;
    else if (!in_high_phase && regs.low_length_override_us != '0)
      len = regs.low_length_override_us;
    else
      len = TIME_W'(regs.auto_period_quarters) * TIME_W'(US_PER_QUARTER);
    elapsed = now - phase_start;
    if (elapsed > len) begin
      in_high_phase = !in_high_phase;
      phase_start   = now;
    end
    if (in_high_phase)
      p = (regs.high_pressure_override != '0) ? regs.high_pressure_override
                                               : regs.auto_high_pressure;
    else
      p = (regs.low_pressure_override != '0) ? regs.low_pressure_override
                                              : LOW_DEFAULT_PRESSURE;
    w   = regs.smoothing_weight;
    avg = (w * smoothed + p) / (w + 1);
    // one-count dither, odd ticks up with saturation, even ticks down to zero
    if (now[0])
      avg = (avg >= PRESSURE_MAX) ? PRESSURE_MAX : avg + 1;
    else
      avg = (avg == 0) ? 0 : avg - 1;
    smoothed = PRESSURE_W'(avg);
    r.target_pressure = smoothed;
    r.phase_high      = in_high_phase;
    r.applied         = 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin
    target_result_t exp_r;
    if (rst) begin
      regs.auto_high_pressure      = PRESSURE_W'(1000);
      regs.auto_period_quarters    = QUARTERS_W'(16);
      regs.high_pressure_override  = '0;
      regs.low_pressure_override   = '0;
      regs.high_length_override_us = '0;
      regs.low_length_override_us  = '0;
      regs.smoothing_weight        = WEIGHT_W'(3);
      initialized   = 1'b0;
      in_high_phase = 1'b0;
      phase_start   = '0;
      smoothed      = '0;
      expected_targets.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_AUTO_HIGH_PRESSURE:   regs.auto_high_pressure      = cfg_data[PRESSURE_W-1:0];
          REG_AUTO_PERIOD_QUARTERS: regs.auto_period_quarters    = cfg_data[QUARTERS_W-1:0];
          REG_HIGH_PRESSURE_OVR:    regs.high_pressure_override  = cfg_data[PRESSURE_W-1:0];
          REG_LOW_PRESSURE_OVR:     regs.low_pressure_override   = cfg_data[PRESSURE_W-1:0];
          REG_HIGH_LENGTH_OVR:      regs.high_length_override_us = cfg_data[TIME_W-1:0];
          REG_LOW_LENGTH_OVR:       regs.low_length_override_us  = cfg_data[TIME_W-1:0];
          REG_SMOOTHING_WEIGHT:     regs.smoothing_weight        = cfg_data[WEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (tick.valid && tick.ready)
        expected_targets.push_back(next_target(tick.now_us, tick.therapy_active));
      if (result.valid && result.ready) begin
        if (expected_targets.size() == 0) begin
          $display("%0t: unexpected result target_pressure=%0d phase_high=%0d applied=%0d",
                   $time, result.target_pressure, result.phase_high, result.applied);
          fails++;
        end else begin
          exp_r = expected_targets.pop_front();
          if (result.target_pressure !== exp_r.target_pressure) begin
            $display("%0t: target_pressure expected %0d got %0d",
                     $time, exp_r.target_pressure, result.target_pressure);
            fails++;
          end
          if (result.phase_high !== exp_r.phase_high) begin
            $display("%0t: phase_high expected %0d got %0d",
                     $time, exp_r.phase_high, result.phase_high);
            fails++;
          end
          if (result.applied !== exp_r.applied) begin
            $display("%0t: applied expected %0d got %0d",
                     $time, exp_r.applied, result.applied);
            fails++;
          end
        end
      end
    end
    waiting = expected_targets.size();
  end

endmodule

// ===== dv/testbench.sv =====
// stimulus and verdict for the alternating pressure target block
`timescale 1ns / 1ps

module testbench;
  import apt_pkg::*;

  // index beyond the register file, writes to it must be dropped
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;
  // generous run-away bound on the cycle count
  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [REG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // no idling on either side while calm is set
  logic calm = 1'b0;
  int unsigned cycles = 0;
  int failures;
  int pending_results;

  // effective phase lengths of the current setting, used to pace timestamps
  logic [TIME_W-1:0] low_len;
  logic [TIME_W-1:0] high_len;

  apt_tick_if   tick_ch();
  apt_result_if result_ch();

  always #5 clk = ~clk;

  alternating_pressure_target_top dut (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  apt_target_compare target_check (
    .clk         (clk),
    .rst         (rst),
    .tick        (tick_ch),
    .result      (result_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (failures),
    .outstanding (pending_results)
  );

  // result side stalls about a third of the time unless calm
  always @(negedge clk) begin
    result_ch.ready = calm || ($urandom_range(0, 99) >= 35);
  end

  // run-away guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // register write, called at a falling edge; unused upper data bits get junk
  task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value,
                         input int width);
    longint mask;
    mask      = (64'd1 << width) - 1;
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = (CFG_DATA_W'($urandom()) & ~CFG_DATA_W'(mask)) | (value & CFG_DATA_W'(mask));
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // one tick request; an optional gap first, then hold until accepted
  task automatic send_tick(input logic [TIME_W-1:0] now, input logic active);
    if (!calm && $urandom_range(0, 99) < 35) begin
      tick_ch.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    tick_ch.valid          = 1'b1;
    tick_ch.now_us         = now;
    tick_ch.therapy_active = active;
    do @(posedge clk); while (!tick_ch.ready);
    @(negedge clk);
  endtask

  // drain every expected result, then let the pipeline go quiet
  task automatic settle();
    tick_ch.valid = 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (24) @(negedge clk);
  endtask

  function automatic logic [PRESSURE_W-1:0] pick_pressure();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return PRESSURE_MAX;
      2:       return PRESSURE_W'($urandom());
      default: return PRESSURE_W'($urandom_range(1, 3000));
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_length();
    case ($urandom_range(0, 15))
      0, 1, 2, 3: return '0;
      4:          return 32'hFFFF_FFFF;
      5:          return $urandom();
      default:    return $urandom_range(1, 3000);
    endcase
  endfunction

  // new random setting of every register, written while the block is idle
  task automatic shuffle_settings();
    logic [PRESSURE_W-1:0] hi_auto;
    logic [PRESSURE_W-1:0] hi_ovr;
    logic [PRESSURE_W-1:0] lo_ovr;
    logic [QUARTERS_W-1:0] quarters;
    logic [WEIGHT_W-1:0]   weight;
    logic [TIME_W-1:0]     hi_ovr_len;
    logic [TIME_W-1:0]     lo_ovr_len;
    logic [TIME_W-1:0]     auto_len;
    hi_auto = pick_pressure();
    hi_ovr  = ($urandom_range(0, 2) == 0) ? '0 : pick_pressure();
    lo_ovr  = ($urandom_range(0, 2) == 0) ? '0 : pick_pressure();
    case ($urandom_range(0, 5))
      0:       quarters = '0;
      1:       quarters = 8'hFF;
      2:       quarters = QUARTERS_W'($urandom());
      default: quarters = QUARTERS_W'($urandom_range(1, 3));
    endcase
    case ($urandom_range(0, 5))
      0:       weight = '0;
      1:       weight = 8'hFF;
      2:       weight = WEIGHT_W'($urandom());
      default: weight = WEIGHT_W'($urandom_range(1, 8));
    endcase
    hi_ovr_len = pick_length();
    lo_ovr_len = pick_length();
    set_reg(REG_AUTO_HIGH_PRESSURE, 32'(hi_auto), PRESSURE_W);
    set_reg(REG_AUTO_PERIOD_QUARTERS, 32'(quarters), QUARTERS_W);
    set_reg(REG_HIGH_PRESSURE_OVR, 32'(hi_ovr), PRESSURE_W);
    set_reg(REG_LOW_PRESSURE_OVR, 32'(lo_ovr), PRESSURE_W);
    set_reg(REG_HIGH_LENGTH_OVR, hi_ovr_len, TIME_W);
    set_reg(REG_LOW_LENGTH_OVR, lo_ovr_len, TIME_W);
    set_reg(REG_SMOOTHING_WEIGHT, 32'(weight), WEIGHT_W);
    if ($urandom_range(0, 2) == 0)
      set_reg(REG_UNUSED, $urandom(), CFG_DATA_W);
    auto_len = TIME_W'(quarters) * TIME_W'(US_PER_QUARTER);
    high_len = (hi_ovr_len != '0) ? hi_ovr_len : auto_len;
    low_len  = (lo_ovr_len != '0) ? lo_ovr_len : auto_len;
  endtask

  // mostly an advancing clock paced by the phase lengths, with jumps and
  // inactive ticks mixed in
  task automatic run_ticks(input int n_items);
    logic [TIME_W-1:0] now;
    longint span;
    now = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 5000) : $urandom();
    repeat (n_items) begin
      if ($urandom_range(0, 19) == 0) begin
        now = $urandom();
      end else begin
        span = 2 * longint'($urandom_range(0, 1) ? low_len : high_len) + 2;
        if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
        now = now + $urandom_range(0, 32'(span));
      end
      send_tick(now, $urandom_range(0, 9) != 0);
    end
  endtask

  initial begin
    tick_ch.valid          = 1'b0;
    tick_ch.now_us         = '0;
    tick_ch.therapy_active = 1'b0;
    result_ch.ready        = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (10) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // reset defaults: 4 s phases, 1000 high, 400 low, weight 3
    send_tick(32'hFFFF_FFFF, 1'b0);   // inactive before the first active tick
    send_tick(32'h0000_0000, 1'b1);   // first active tick starts the low phase
    send_tick(32'h0000_0001, 1'b1);
    send_tick(32'd4_000_000, 1'b1);   // elapsed equals the length, no toggle
    send_tick(32'd4_000_001, 1'b1);   // just past it, goes high
    send_tick(32'hFFFF_FFFF, 1'b1);
    send_tick(32'h0000_0005, 1'b1);   // timer wrapped, small elapsed
    send_tick(32'h0000_0000, 1'b0);   // inactive mid-run leaves state alone
    settle();

    // zero phase length, zero high pressure, no smoothing: dither clamps at zero
    set_reg(REG_AUTO_HIGH_PRESSURE, 32'd0, PRESSURE_W);
    set_reg(REG_HIGH_PRESSURE_OVR, 32'd0, PRESSURE_W);
    set_reg(REG_AUTO_PERIOD_QUARTERS, 32'd0, QUARTERS_W);
    set_reg(REG_HIGH_LENGTH_OVR, 32'd0, TIME_W);
    set_reg(REG_LOW_LENGTH_OVR, 32'd0, TIME_W);
    set_reg(REG_SMOOTHING_WEIGHT, 32'd0, WEIGHT_W);
    send_tick(32'd10, 1'b1);
    send_tick(32'd10, 1'b1);          // zero elapsed keeps the phase
    send_tick(32'd11, 1'b1);
    send_tick(32'd12, 1'b1);
    settle();

    // full-scale pressures with odd timestamps saturate the target
    set_reg(REG_HIGH_PRESSURE_OVR, 32'hFFF, PRESSURE_W);
    set_reg(REG_LOW_PRESSURE_OVR, 32'hFFF, PRESSURE_W);
    set_reg(REG_HIGH_LENGTH_OVR, 32'd1, TIME_W);
    set_reg(REG_LOW_LENGTH_OVR, 32'd1, TIME_W);
    send_tick(32'd13, 1'b1);
    send_tick(32'd15, 1'b1);
    send_tick(32'd16, 1'b1);
    settle();

    // heaviest smoothing, longest phases, and a write to a missing register
    set_reg(REG_SMOOTHING_WEIGHT, 32'hFF, WEIGHT_W);
    set_reg(REG_AUTO_PERIOD_QUARTERS, 32'hFF, QUARTERS_W);
    set_reg(REG_HIGH_LENGTH_OVR, 32'hFFFF_FFFF, TIME_W);
    set_reg(REG_LOW_LENGTH_OVR, 32'hFFFF_FFFF, TIME_W);
    set_reg(REG_UNUSED, 32'h0000_0001, CFG_DATA_W);
    send_tick(32'hFFFF_FFFF, 1'b1);
    send_tick(32'h0000_0000, 1'b1);
    send_tick(32'h8000_0000, 1'b1);
    settle();

    // random settings, each followed by a run of paced ticks
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      shuffle_settings();
      calm = (ph == 3);
      run_ticks(PHASE_ITEMS);
      settle();
      calm = 1'b0;
    end

    repeat (40) @(negedge clk);
    if (failures == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== alternating_pressure_target_top.f =====
src/apt_pkg.sv
src/apt_if.sv
src/apt_cfg_regs.sv
src/apt_div.sv
src/alternating_pressure_target_top.sv
dv/apt_target_compare.sv
dv/testbench.sv
